FILE: src/mdms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdms_pkg
// Shared types and constants for the data-memory stage: transfer payloads,
// access codes and the control and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package mdms_pkg;

    // default memory size in bytes
    localparam int MEM_BYTES_DEFAULT = 1024;

    // access command codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_STORE = 2'd2;

    // access size codes
    localparam logic [2:0] SIZE_WORD   = 3'd0;
    localparam logic [2:0] SIZE_HALF_S = 3'd1;
    localparam logic [2:0] SIZE_HALF_U = 3'd2;
    localparam logic [2:0] SIZE_BYTE_S = 3'd3;
    localparam logic [2:0] SIZE_BYTE_U = 3'd4;

    // request payload
    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  access_size;
        logic [31:0] byte_address;
        logic [31:0] store_value;
        logic        is_halt;
    } req_item_t;

    // response payload
    typedef struct packed {
        logic [31:0] load_value;
        logic        overflow_flag;
        logic        misalign_flag;
        logic        halt_seen;
    } rsp_item_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clear_en;
        logic capture;
        logic mem_en;
        logic finish;
    } ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic clear_done;
    } sts_t;

endpackage

FILE: src/mdms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdms_ctrl
// Controller of the data-memory stage: runs the memory clearing sweep after
// reset, then steps each transfer through capture, memory access and result.
// ----------------------------------------------------------------------------
module mdms_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    input  mdms_pkg::sts_t sts,
    output mdms_pkg::ctl_t ctl
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MEM,
        ST_FMT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   rsp_free;

    // response register can take a new result
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        ctl          = '0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear_en = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_MEM;
                end
            end
            ST_MEM:
            begin
                ctl.mem_en = 1'b1;
                state_next = ST_FMT;
            end
            ST_FMT:
            begin
                if (rsp_free)
                begin
                    ctl.finish     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

FILE: src/mdms_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdms_datapath
// Datapath of the data-memory stage: big-endian byte store held as four
// byte-lane memories sharing the word rows, range and alignment checks,
// sticky flags, held load value, halt register and response register.
// ----------------------------------------------------------------------------
module mdms_datapath #(
    parameter int MEM_BYTES = mdms_pkg::MEM_BYTES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mdms_pkg::ctl_t      ctl,
    output mdms_pkg::sts_t      sts,
    input  mdms_pkg::req_item_t req,
    output mdms_pkg::rsp_item_t rsp
);

    localparam int ROWS = (MEM_BYTES + 3) / 4;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    mdms_pkg::req_item_t item_reg;
    mdms_pkg::rsp_item_t rsp_reg;

    logic [RW-1:0]  clr_cnt_reg;
    logic           ovf_reg;
    logic           mis_reg;
    logic           halt_reg;
    logic [31:0]    held_reg;
    logic [31:0]    held_next;
    logic           load_pend_reg;
    logic [3:0][7:0] rd_byte_reg;

    logic           is_word;
    logic           is_half;
    logic           access;
    logic [1:0]     span;
    logic [32:0]    last_byte;
    logic           ovf_hit;
    logic           mis_hit;
    logic           ovf_next;
    logic           mis_next;
    logic           suppressed;
    logic [RW-1:0]  row;
    logic [RW-1:0]  waddr;
    logic [3:0]     lane_we;
    logic [3:0]     acc_be;
    logic [31:0]    acc_wdata;
    logic [31:0]    wdata;
    logic           rd_en;
    logic [31:0]    rd_word;
    logic [15:0]    rd_half;
    logic [7:0]     rd_byte;
    logic [31:0]    load_ext;

    // size decode and access qualification
    always_comb
    begin
        is_word = (item_reg.access_size == mdms_pkg::SIZE_WORD);
        is_half = (item_reg.access_size == mdms_pkg::SIZE_HALF_S)
               || (item_reg.access_size == mdms_pkg::SIZE_HALF_U);
        access  = ((item_reg.cmd == mdms_pkg::CMD_LOAD)
               ||  (item_reg.cmd == mdms_pkg::CMD_STORE))
               && (item_reg.access_size <= mdms_pkg::SIZE_BYTE_U);
        span    = is_word ? 2'd3 : (is_half ? 2'd1 : 2'd0);
    end

    // range and alignment checks
    assign last_byte  = {1'b0, item_reg.byte_address} + 33'(span);
    assign ovf_hit    = (last_byte >= 33'(MEM_BYTES));
    assign mis_hit    = is_word ? (item_reg.byte_address[1:0] != 2'b00)
                      : (is_half ? item_reg.byte_address[0] : 1'b0);
    assign ovf_next   = ovf_reg || (access && ovf_hit);
    assign mis_next   = mis_reg || (access && mis_hit);
    assign suppressed = access && (ovf_next || mis_next);

    // byte enables and store data, lane 3 is the lowest address
    always_comb
    begin
        if (is_word)
        begin
            acc_be    = 4'b1111;
            acc_wdata = item_reg.store_value;
        end
        else if (is_half)
        begin
            acc_be    = item_reg.byte_address[1] ? 4'b0011 : 4'b1100;
            acc_wdata = {2{item_reg.store_value[15:0]}};
        end
        else
        begin
            acc_be    = 4'b1000 >> item_reg.byte_address[1:0];
            acc_wdata = {4{item_reg.store_value[7:0]}};
        end
    end

    // memory port selection between clearing sweep and access
    assign row   = item_reg.byte_address[RW+1:2];
    assign waddr = ctl.clear_en ? clr_cnt_reg : row;
    assign wdata = ctl.clear_en ? 32'd0 : acc_wdata;
    assign rd_en = ctl.mem_en && access && !suppressed
                && (item_reg.cmd == mdms_pkg::CMD_LOAD);

    always_comb
    begin
        if (ctl.clear_en)
        begin
            lane_we = 4'b1111;
        end
        else if (ctl.mem_en && access && !suppressed
                 && (item_reg.cmd == mdms_pkg::CMD_STORE))
        begin
            lane_we = acc_be;
        end
        else
        begin
            lane_we = 4'b0000;
        end
    end

    // byte-lane memories
    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        logic [7:0] lane_mem [ROWS];

        always_ff @(posedge clk)
        begin
            if (lane_we[g])
            begin
                lane_mem[waddr] <= wdata[8*g +: 8];
            end
            if (rd_en)
            begin
                rd_byte_reg[g] <= lane_mem[row];
            end
        end
    end

    // clearing sweep counter
    assign sts.clear_done = (clr_cnt_reg == RW'(ROWS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctl.clear_en && !sts.clear_done)
        begin
            clr_cnt_reg <= clr_cnt_reg + RW'(1);
        end
    end

    // load extraction and extension
    always_comb
    begin
        rd_word = rd_byte_reg;
        rd_half = item_reg.byte_address[1] ? rd_word[15:0] : rd_word[31:16];
        rd_byte = 8'(rd_word >> {~item_reg.byte_address[1:0], 3'b000});
        case (item_reg.access_size)
            mdms_pkg::SIZE_WORD:   load_ext = rd_word;
            mdms_pkg::SIZE_HALF_S: load_ext = {{16{rd_half[15]}}, rd_half};
            mdms_pkg::SIZE_HALF_U: load_ext = {16'd0, rd_half};
            mdms_pkg::SIZE_BYTE_S: load_ext = {{24{rd_byte[7]}}, rd_byte};
            default:               load_ext = {24'd0, rd_byte};
        endcase
        held_next = load_pend_reg ? load_ext : held_reg;
    end

    // captured request and response payload
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            item_reg <= req;
        end
        if (ctl.finish)
        begin
            rsp_reg.load_value    <= held_next;
            rsp_reg.overflow_flag <= ovf_reg;
            rsp_reg.misalign_flag <= mis_reg;
            rsp_reg.halt_seen     <= halt_reg;
        end
    end

    // architectural state: sticky flags, halt and held load value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg       <= 1'b0;
            mis_reg       <= 1'b0;
            halt_reg      <= 1'b0;
            held_reg      <= 32'd0;
            load_pend_reg <= 1'b0;
        end
        else
        begin
            if (ctl.mem_en)
            begin
                ovf_reg       <= ovf_next;
                mis_reg       <= mis_next;
                load_pend_reg <= rd_en;
                if (!suppressed)
                begin
                    halt_reg <= item_reg.is_halt;
                end
            end
            if (ctl.finish)
            begin
                held_reg <= held_next;
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

FILE: src/mips_data_memory_stage_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_data_memory_stage_core
// Data-memory stage of a pipeline with a big-endian byte store.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one access per
//   transfer: load, store or no access, with size, address, store data and
//   the halt mark. rsp channel (rsp_valid / rsp_stall / rsp) returns one
//   result per transfer: held load value, sticky overflow and misalign
//   flags and the halt register.
//   A new request is taken only once the controller has stepped through
//   capture, memory access (one read or write port, registered read) and
//   result formatting, and the response register can take the result.
//   Reset: the store is cleared by a sweep of one word row per cycle over
//   all (MEM_BYTES + 3) / 4 rows (256 for 1024 bytes); req_stall is high
//   until the sweep ends. Flags, halt and held value reset to zero.
//   When the receiver stalls, the response register holds its result; one
//   more request is taken and processed, then waits for the register.
// ----------------------------------------------------------------------------
module mips_data_memory_stage_core #(
    parameter int MEM_BYTES = mdms_pkg::MEM_BYTES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  mdms_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mdms_pkg::rsp_item_t rsp
);

    mdms_pkg::ctl_t ctl;
    mdms_pkg::sts_t sts;

    // controller
    mdms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // datapath
    mdms_datapath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the data-memory stage. A short table of access
// rows runs first, then random load/store traffic under three idle
// profiles, then the sticky error cases and a random tail. Each result is
// compared field by field against the table's expected values or a local
// model of the byte store, sticky flags, held load value and halt register.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MEM_BYTES   = mdms_pkg::MEM_BYTES_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PER_PHASE = 120;
    localparam int TAIL_ITEMS  = 30;

    // codes the package leaves unnamed
    localparam logic [1:0] CMD_BOTH       = 2'd3;
    localparam logic [2:0] SIZE_UNUSED_LO = 3'd5;
    localparam logic [2:0] SIZE_UNUSED_HI = 3'd7;

    typedef struct {
        mdms_pkg::req_item_t item;
        bit                  has_exp;
        mdms_pkg::rsp_item_t exp;
    } access_row_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    mdms_pkg::req_item_t req       = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    mdms_pkg::rsp_item_t rsp;

    // model state
    logic [7:0]  mem_img [MEM_BYTES];
    logic        img_overflow    = 1'b0;
    logic        img_misalign    = 1'b0;
    logic [31:0] img_load_value  = '0;
    logic        img_halt        = 1'b0;

    mdms_pkg::rsp_item_t pending_results [$];
    access_row_t         access_table [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;

    mips_data_memory_stage_core #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // model of one access: updates the local state, returns the result
    function automatic mdms_pkg::rsp_item_t predict_stage_result(
        input mdms_pkg::req_item_t it);
        mdms_pkg::rsp_item_t res;
        int unsigned len;
        int unsigned a;
        logic [33:0] last;
        logic [31:0] v;
        logic [31:0] word;
        bit          active;
        bit          suppressed;
        active     = (it.cmd == mdms_pkg::CMD_LOAD || it.cmd == mdms_pkg::CMD_STORE)
                     && it.access_size <= mdms_pkg::SIZE_BYTE_U;
        suppressed = 1'b0;
        v          = it.store_value;
        if (active)
        begin
            len  = (it.access_size == mdms_pkg::SIZE_WORD) ? 4 :
                   (it.access_size <= mdms_pkg::SIZE_HALF_U) ? 2 : 1;
            last = {2'b00, it.byte_address} + 34'(len) - 34'd1;
            if (last >= 34'(MEM_BYTES))
                img_overflow = 1'b1;
            if (len > 1 && (it.byte_address & (len - 1)) != 0)
                img_misalign = 1'b1;
            suppressed = img_overflow || img_misalign;
            if (!suppressed)
            begin
                a = it.byte_address;
                if (it.cmd == mdms_pkg::CMD_STORE)
                begin
                    // big-endian: most significant byte at the lowest address
                    case (len)
                        4:
                        begin
                            mem_img[a]     = v[31:24];
                            mem_img[a + 1] = v[23:16];
                            mem_img[a + 2] = v[15:8];
                            mem_img[a + 3] = v[7:0];
                        end
                        2:
                        begin
                            mem_img[a]     = v[15:8];
                            mem_img[a + 1] = v[7:0];
                        end
                        default:
                            mem_img[a] = v[7:0];
                    endcase
                end
                else
                begin
                    case (len)
                        4:
                            word = {mem_img[a], mem_img[a + 1], mem_img[a + 2],
                                    mem_img[a + 3]};
                        2:
                            word = {{16{(it.access_size == mdms_pkg::SIZE_HALF_S)
                                        && mem_img[a][7]}},
                                    mem_img[a], mem_img[a + 1]};
                        default:
                            word = {{24{(it.access_size == mdms_pkg::SIZE_BYTE_S)
                                        && mem_img[a][7]}}, mem_img[a]};
                    endcase
                    img_load_value = word;
                end
            end
        end
        if (!suppressed)
            img_halt = it.is_halt;
        res.load_value    = img_load_value;
        res.overflow_flag = img_overflow;
        res.misalign_flag = img_misalign;
        res.halt_seen     = img_halt;
        return res;
    endfunction

    // one table row; expected fields are used only when has_exp is set
    task automatic add_row(input logic [1:0] cmd, input logic [2:0] size,
                           input logic [31:0] addr, input logic [31:0] value,
                           input logic halt, input bit has_exp,
                           input logic [31:0] exp_load, input logic exp_ovf,
                           input logic exp_mis, input logic exp_halt);
        access_row_t row;
        row.item.cmd          = cmd;
        row.item.access_size  = size;
        row.item.byte_address = addr;
        row.item.store_value  = value;
        row.item.is_halt      = halt;
        row.has_exp           = has_exp;
        row.exp.load_value    = exp_load;
        row.exp.overflow_flag = exp_ovf;
        row.exp.misalign_flag = exp_mis;
        row.exp.halt_seen     = exp_halt;
        access_table.push_back(row);
    endtask

    // in-range, aligned load or store, mostly in a small window so loads
    // hit recently stored data
    function automatic mdms_pkg::req_item_t rand_legal_access();
        mdms_pkg::req_item_t it;
        int unsigned len;
        int unsigned addr;
        it.cmd         = $urandom_range(0, 1) ? mdms_pkg::CMD_STORE : mdms_pkg::CMD_LOAD;
        it.access_size = 3'($urandom_range(mdms_pkg::SIZE_WORD, mdms_pkg::SIZE_BYTE_U));
        len = (it.access_size == mdms_pkg::SIZE_WORD) ? 4 :
              (it.access_size <= mdms_pkg::SIZE_HALF_U) ? 2 : 1;
        case ($urandom_range(0, 7))
            0:       addr = MEM_BYTES - len;
            1, 2:    addr = $urandom_range(0, MEM_BYTES - 1);
            default: addr = $urandom_range(0, 31);
        endcase
        it.byte_address = addr & ~(len - 1);
        it.store_value  = $urandom;
        it.is_halt      = ($urandom_range(0, 15) == 0);
        return it;
    endfunction

    // items that make no memory access: no command, both bits, unused size
    function automatic mdms_pkg::req_item_t rand_ignored_item();
        mdms_pkg::req_item_t it;
        it.cmd = 2'($urandom_range(0, 3));
        if (it.cmd == mdms_pkg::CMD_LOAD || it.cmd == mdms_pkg::CMD_STORE)
            it.access_size = 3'($urandom_range(SIZE_UNUSED_LO, SIZE_UNUSED_HI));
        else
            it.access_size = 3'($urandom_range(0, 7));
        it.byte_address = $urandom;
        it.store_value  = $urandom;
        it.is_halt      = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // anything the fields allow, errors included
    function automatic mdms_pkg::req_item_t rand_any_item();
        mdms_pkg::req_item_t it;
        it.cmd          = 2'($urandom_range(0, 3));
        it.access_size  = 3'($urandom_range(0, 7));
        it.byte_address = $urandom_range(0, 1) ? $urandom
                                               : $urandom_range(0, MEM_BYTES + 7);
        it.store_value  = $urandom;
        it.is_halt      = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // drive one request transfer, then record its expected result
    task automatic send_access(input mdms_pkg::req_item_t it, input bit has_exp,
                               input mdms_pkg::rsp_item_t exp);
        mdms_pkg::rsp_item_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = predict_stage_result(it);
        pending_results.push_back(has_exp ? exp : predicted);
        @(negedge clk);
    endtask

    // receiver stall
    always @(negedge clk)
    begin
        if (rst_n)
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // result check
    always @(posedge clk)
    begin
        mdms_pkg::rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: load %h ovf %b mis %b halt %b",
                             rsp.load_value, rsp.overflow_flag,
                             rsp.misalign_flag, rsp.halt_seen);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.load_value !== want.load_value
                    || rsp.overflow_flag !== want.overflow_flag
                    || rsp.misalign_flag !== want.misalign_flag
                    || rsp.halt_seen !== want.halt_seen)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp load %h ovf %b mis %b halt %b, %s",
                                 want.load_value, want.overflow_flag,
                                 want.misalign_flag, want.halt_seen,
                                 $sformatf("got load %h ovf %b mis %b halt %b",
                                           rsp.load_value, rsp.overflow_flag,
                                           rsp.misalign_flag, rsp.halt_seen));
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int                  lead_rows;
        int                  accesses;
        mdms_pkg::req_item_t it;
        mdms_pkg::rsp_item_t none;

        none = '0;
        for (int i = 0; i < MEM_BYTES; i++)
            mem_img[i] = 8'h00;

        // leading rows: byte order, extension, memory edges, no-access cases
        add_row(mdms_pkg::CMD_LOAD,  mdms_pkg::SIZE_WORD,   32'd0, 32'd0, 1'b0,
                1, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_STORE, mdms_pkg::SIZE_WORD,   32'd0, 32'h80FF_7F01, 1'b0,
                1, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_LOAD,  mdms_pkg::SIZE_WORD,   32'd0, 32'd0, 1'b0,
                1, 32'h80FF_7F01, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_LOAD,  mdms_pkg::SIZE_HALF_S, 32'd0, 32'd0, 1'b0,
                1, 32'hFFFF_80FF, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_LOAD,  mdms_pkg::SIZE_HALF_U, 32'd0, 32'd0, 1'b0,
                1, 32'h0000_80FF, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_LOAD,  mdms_pkg::SIZE_BYTE_S, 32'd0, 32'd0, 1'b0,
                1, 32'hFFFF_FF80, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_LOAD,  mdms_pkg::SIZE_BYTE_S, 32'd1, 32'd0, 1'b0,
                1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_LOAD,  mdms_pkg::SIZE_BYTE_U, 32'd3, 32'd0, 1'b0,
                1, 32'h0000_0001, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_STORE, mdms_pkg::SIZE_WORD,   MEM_BYTES - 4, 32'hFFFF_FFFF,
                1'b0, 1, 32'h0000_0001, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_STORE, mdms_pkg::SIZE_HALF_U, MEM_BYTES - 2, 32'h1234_ABCD,
                1'b0, 1, 32'h0000_0001, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_STORE, mdms_pkg::SIZE_BYTE_S, MEM_BYTES - 1, 32'h0000_00A5,
                1'b0, 1, 32'h0000_0001, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_LOAD,  mdms_pkg::SIZE_WORD,   MEM_BYTES - 4, 32'd0, 1'b0,
                1, 32'hFFFF_ABA5, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_STORE, mdms_pkg::SIZE_HALF_S, 32'd4, 32'hFFFF_8001, 1'b0,
                0, none.load_value, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_STORE, mdms_pkg::SIZE_BYTE_U, 32'd7, 32'hFFFF_FF7E, 1'b0,
                0, none.load_value, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_LOAD,  mdms_pkg::SIZE_WORD,   32'd4, 32'd0, 1'b0,
                1, 32'h8001_007E, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_NONE,  mdms_pkg::SIZE_WORD,   32'hFFFF_FFFF, 32'hFFFF_FFFF,
                1'b1, 1, 32'h8001_007E, 1'b0, 1'b0, 1'b1);
        add_row(CMD_BOTH,  mdms_pkg::SIZE_WORD,   32'd0, 32'd0, 1'b0,
                1, 32'h8001_007E, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_LOAD,  SIZE_UNUSED_HI, 32'hFFFF_FFFF, 32'd0, 1'b1,
                1, 32'h8001_007E, 1'b0, 1'b0, 1'b1);
        add_row(mdms_pkg::CMD_STORE, SIZE_UNUSED_LO, 32'd0, 32'd0, 1'b0,
                1, 32'h8001_007E, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_LOAD,  mdms_pkg::SIZE_WORD,   32'd0, 32'd0, 1'b1,
                1, 32'h80FF_7F01, 1'b0, 1'b0, 1'b1);
        lead_rows = access_table.size();

        // closing rows: sticky flags and the accesses they suppress
        add_row(mdms_pkg::CMD_STORE, mdms_pkg::SIZE_WORD,   32'd0, 32'h5A5A_C3C3, 1'b0,
                0, none.load_value, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_LOAD,  mdms_pkg::SIZE_WORD,   32'd0, 32'd0, 1'b0,
                1, 32'h5A5A_C3C3, 1'b0, 1'b0, 1'b0);
        add_row(mdms_pkg::CMD_LOAD,  mdms_pkg::SIZE_HALF_U, 32'd3, 32'd0, 1'b1,
                1, 32'h5A5A_C3C3, 1'b0, 1'b1, 1'b0);
        add_row(mdms_pkg::CMD_NONE,  mdms_pkg::SIZE_WORD,   32'd0, 32'd0, 1'b1,
                1, 32'h5A5A_C3C3, 1'b0, 1'b1, 1'b1);
        add_row(mdms_pkg::CMD_STORE, mdms_pkg::SIZE_BYTE_U, MEM_BYTES, 32'hFFFF_FFFF, 1'b0,
                1, 32'h5A5A_C3C3, 1'b1, 1'b1, 1'b1);
        // signed byte load must also be suppressed
        add_row(mdms_pkg::CMD_LOAD,  mdms_pkg::SIZE_BYTE_S, 32'd0, 32'd0, 1'b0,
                1, 32'h5A5A_C3C3, 1'b1, 1'b1, 1'b1);
        add_row(mdms_pkg::CMD_LOAD,  mdms_pkg::SIZE_WORD,   32'hFFFF_FFFD, 32'd0, 1'b0,
                1, 32'h5A5A_C3C3, 1'b1, 1'b1, 1'b1);
        add_row(CMD_BOTH,  mdms_pkg::SIZE_WORD,   32'd0, 32'd0, 1'b0,
                1, 32'h5A5A_C3C3, 1'b1, 1'b1, 1'b0);

        // reset
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < lead_rows; i++)
            send_access(access_table[i].item, access_table[i].has_exp,
                        access_table[i].exp);

        // random traffic under three idle profiles
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 7;
                    recv_idle_pct = 63;
                end
                1:
                begin
                    send_idle_pct = 63;
                    recv_idle_pct = 7;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            accesses = 0;
            while (accesses < RAND_PER_PHASE)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    it = rand_ignored_item();
                end
                else
                begin
                    it = rand_legal_access();
                    accesses++;
                end
                send_access(it, 0, none);
            end
        end

        // error cases and a random tail once the flags are set
        send_idle_pct = 7;
        recv_idle_pct = 63;
        for (int i = lead_rows; i < access_table.size(); i++)
            send_access(access_table[i].item, access_table[i].has_exp,
                        access_table[i].exp);
        for (int i = 0; i < TAIL_ITEMS; i++)
            send_access(rand_any_item(), 0, none);
        req_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: mips_data_memory_stage_core.f
src/mdms_pkg.sv
src/mdms_ctrl.sv
src/mdms_datapath.sv
src/mips_data_memory_stage_core.sv
verif/tb_top.sv
